// ===== rtl/utf8d_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Types, constants and byte-level decode functions shared by the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8d_pkg;

    localparam logic [15:0] QMARK_CP    = 16'd63;
    localparam int          MAX_RESULTS = 3;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_LEAD  = 3'd1,
        PH_HELD  = 3'd2,
        PH_WAIT4 = 3'd3
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [7:0]  lead;
        logic [7:0]  held;
    } dec_state_t;

    typedef struct packed {
        logic [1:0]  count;
        logic [15:0] cp0;
        logic [15:0] cp1;
        logic [15:0] cp2;
    } dec_res_t;

    typedef struct packed {
        logic [15:0] cp;
        logic [1:0]  len;
    } unit_t;

    function automatic logic is_cont(input logic [7:0] c);
        is_cont = (c[7:6] == 2'b10);
    endfunction

    // Length in bytes of a complete sequence that starts with this byte.
    function automatic logic [2:0] seq_len(input logic [7:0] c);
        logic [2:0] len;
        len = 3'd1;
        if (c[7] == 1'b0)
            len = 3'd1;
        else if (c[7:5] == 3'b110)
            len = 3'd2;
        else if (c[7:4] == 4'b1110)
            len = 3'd3;
        else if (c[7:3] == 5'b11110)
            len = 3'd4;
        return len;
    endfunction

    // Decodes one unit from up to three bytes, of which avail are present.
    function automatic unit_t unit_decode(
        input logic [7:0] c0,
        input logic [7:0] c1,
        input logic [7:0] c2,
        input logic [1:0] avail
    );
        unit_t u;
        u.cp  = QMARK_CP;
        u.len = 2'd1;
        if (c0[7] == 1'b0)
        begin
            u.cp = {8'h00, c0};
        end
        else if (c0[7:5] == 3'b110 && avail >= 2'd2)
        begin
            u.len = 2'd2;
            if (is_cont(c1))
                u.cp = {5'b00000, c0[4:0], c1[5:0]};
        end
        else if (c0[7:4] == 4'b1110 && avail == 2'd3)
        begin
            u.len = 2'd3;
            if (is_cont(c1) && is_cont(c2))
                u.cp = {c0[3:0], c1[5:0], c2[5:0]};
        end
        return u;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/utf8d_decode.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder step logic
// Combinational decode of one byte against the pending sequence state.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8d_decode (
    input  utf8d_pkg::dec_state_t state,
    input  logic [7:0]            byte_in,
    input  logic                  fin,
    output utf8d_pkg::dec_state_t state_next,
    output utf8d_pkg::dec_res_t   res
);
    import utf8d_pkg::*;

    logic [7:0] run_buf [8];
    logic [1:0] run_n;
    logic [2:0] need;
    logic       hold;
    unit_t      u0;
    unit_t      u1;
    unit_t      u2;
    logic [2:0] off1;
    logic [2:0] off2;
    logic [2:0] n3;

    // Assemble the run of known bytes; unused places read as zero.
    always_comb
    begin
        for (int i = 0; i < 8; i++)
            run_buf[i] = 8'h00;
        run_n = 2'd1;
        unique case (state.phase)
            PH_LEAD:
            begin
                run_buf[0] = state.lead;
                run_buf[1] = byte_in;
                run_n      = 2'd2;
            end
            PH_HELD:
            begin
                run_buf[0] = state.lead;
                run_buf[1] = state.held;
                run_buf[2] = byte_in;
                run_n      = 2'd3;
            end
            default:
            begin
                run_buf[0] = byte_in;
                run_n      = 2'd1;
            end
        endcase
    end

    assign n3   = {1'b0, run_n};
    assign need = seq_len(run_buf[0]);
    assign hold = (state.phase != PH_WAIT4) && !fin && (n3 < need);

    // Next state.
    always_comb
    begin
        state_next.phase = PH_IDLE;
        state_next.lead  = 8'h00;
        state_next.held  = 8'h00;
        if (hold)
        begin
            state_next.lead = state.lead;
            state_next.held = state.held;
            unique case (run_n)
                2'd1:
                begin
                    state_next.phase = PH_LEAD;
                    state_next.lead  = byte_in;
                end
                2'd2:
                begin
                    state_next.phase = PH_HELD;
                    state_next.held  = byte_in;
                end
                default:
                begin
                    state_next.phase = PH_WAIT4;
                    state_next.held  = 8'h00;
                end
            endcase
        end
    end

    // Units of the run, each starting where the previous one ended.
    always_comb
    begin
        u0   = unit_decode(run_buf[0], run_buf[1], run_buf[2], run_n);
        off1 = {1'b0, u0.len};
        u1   = unit_decode(run_buf[off1], run_buf[3'(off1 + 3'd1)],
                           run_buf[3'(off1 + 3'd2)], 2'(n3 - off1));
        off2 = 3'(off1 + {1'b0, u1.len});
        u2   = unit_decode(run_buf[off2], run_buf[3'(off2 + 3'd1)],
                           run_buf[3'(off2 + 3'd2)], 2'(n3 - off2));
    end

    // Results.
    always_comb
    begin
        res.count = 2'd0;
        res.cp0   = QMARK_CP;
        res.cp1   = QMARK_CP;
        res.cp2   = QMARK_CP;
        if (state.phase == PH_WAIT4)
        begin
            res.count = 2'd1;
        end
        else if (!hold)
        begin
            res.cp0   = u0.cp;
            res.cp1   = u1.cp;
            res.cp2   = u2.cp;
            res.count = 2'(2'd1 + {1'b0, (off1 < n3)} + {1'b0, (off2 < n3)});
        end
    end

endmodule

`default_nettype wire

// ===== rtl/utf8d_out_buf.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder result buffer
// Holds the up to three code points of one byte and hands them out in order.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8d_out_buf (
    input  logic                clk,
    input  logic                rst_n,
    input  utf8d_pkg::dec_res_t res,
    input  logic                res_fin,
    input  logic                load,
    output logic                can_load,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,  // [15:0] code_point
    output logic                m_tuser,  // [0] run_last
    output logic                m_tlast   // text_end
);
    import utf8d_pkg::*;

    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    logic [15:0] slot_reg [MAX_RESULTS];
    logic [15:0] slot_next [MAX_RESULTS];
    logic        fin_reg;
    logic        fin_next;
    logic        take;

    assign take     = m_tvalid && m_tready;
    assign can_load = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_tready);

    always_comb
    begin
        cnt_next = cnt_reg;
        fin_next = fin_reg;
        for (int i = 0; i < MAX_RESULTS; i++)
            slot_next[i] = slot_reg[i];
        if (load)
        begin
            cnt_next     = res.count;
            fin_next     = res_fin;
            slot_next[0] = res.cp0;
            slot_next[1] = res.cp1;
            slot_next[2] = res.cp2;
        end
        else if (take)
        begin
            cnt_next = cnt_reg - 2'd1;
            for (int i = 0; i < MAX_RESULTS - 1; i++)
                slot_next[i] = slot_reg[i + 1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            fin_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            fin_reg <= fin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
            slot_reg[i] <= slot_next[i];
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = slot_reg[0];
    assign m_tuser  = (cnt_reg == 2'd1);
    assign m_tlast  = (cnt_reg == 2'd1) && fin_reg;

    // A stalled buffer must not be reloaded or drained.
    a_stall_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != 2'd0 && !m_tready) |=> (cnt_reg == $past(cnt_reg)))
        else $error("result count changed while the output was stalled");

    // The end of the text is always the last result of its byte.
    a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> m_tuser)
        else $error("text end flagged on a result that is not the last of its byte");

endmodule

`default_nettype wire

// ===== rtl/utf8_codepoint_decoder_core.sv =====
// ----------------------------------------------------------------------------
// UTF-8 code point decoder
// Turns a byte stream of UTF-8 text into 16-bit code points, '?' on errors.
// ----------------------------------------------------------------------------
//  Port group | Dir | tdata            | tuser        | tlast
//  s_*        | in  | [7:0] text_byte  | -            | byte_is_final
//  m_*        | out | [15:0] code_point| [0] run_last | text_end
//
//  An accepted byte waits in the input register until the result buffer can
//  take its results, which are decoded and loaded into the buffer at that
//  edge; the first result is offered from that edge on. One byte is taken
//  per cycle while each byte gives at most one result and m_tready is held
//  high; a byte that gives more results keeps the result buffer busy until
//  they have left, so the byte behind it waits in the input register.
//  Reset empties both registers and clears the state.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_codepoint_decoder_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,   // byte_is_final
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] code_point
    output logic        m_tuser,   // [0] run_last
    output logic        m_tlast    // text_end
);
    import utf8d_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_fin_reg;
    logic       can_load;
    logic       move;

    phase_t     phase_reg;
    logic [7:0] lead_reg;
    logic [7:0] held_reg;
    dec_state_t state_cur;
    dec_state_t state_next;
    dec_res_t   dec_res;

    assign move     = in_valid_reg && can_load;
    assign s_tready = !in_valid_reg || can_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tvalid && s_tready)
            in_valid_reg <= 1'b1;
        else if (move)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_fin_reg  <= s_tlast;
        end
    end

    assign state_cur.phase = phase_reg;
    assign state_cur.lead  = lead_reg;
    assign state_cur.held  = held_reg;

    utf8d_decode u_decode (
        .state      (state_cur),
        .byte_in    (in_byte_reg),
        .fin        (in_fin_reg),
        .state_next (state_next),
        .res        (dec_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            lead_reg  <= 8'h00;
            held_reg  <= 8'h00;
        end
        else if (move)
        begin
            phase_reg <= state_next.phase;
            lead_reg  <= state_next.lead;
            held_reg  <= state_next.held;
        end
    end

    utf8d_out_buf u_out_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .res      (dec_res),
        .res_fin  (in_fin_reg),
        .load     (move),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // A byte that gives no result always leaves a sequence pending.
    a_silent_byte_pends: assert property (@(posedge clk) disable iff (!rst_n)
        (move && dec_res.count == 2'd0) |=> (phase_reg != PH_IDLE))
        else $error("byte gave no result but no sequence is pending");

    // The final byte of a text leaves the decoder idle.
    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (move && in_fin_reg) |=> (phase_reg == PH_IDLE))
        else $error("decoder not idle after the final byte");

endmodule

`default_nettype wire
